### rtl/core/gbre_pkg.sv
// Shared types and constants for the GF(2) bit-matrix row engine.
// No dependencies; imported by the word ALU and the top level.
`default_nettype none

package gbre_pkg;

    localparam int WORD_W    = 32;
    localparam int BIT_SEL_W = 5;
    localparam int CFG_W     = 3;
    localparam int POS_W     = 7;

    localparam logic [CFG_W-1:0] ROW_WORDS_RESET = 3'd4;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_TOGGLE = 2'd1,
        MODE_ADD    = 2'd2,
        MODE_GAP    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [WORD_W-1:0]    wr_data;
        logic                 bit_val;
        logic                 zero_found;
        logic [BIT_SEL_W-1:0] zero_pos;
    } alu_out_t;

endpackage

`default_nettype wire

### rtl/core/gbre_word_ram.sv
// Matrix word store: one write port, two read ports with registered data.
// No dependencies.
`default_nettype none

module gbre_word_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [31:0]   rdata_a,
    output logic      [31:0]   rdata_b
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/core/gbre_word_alu.sv
// Shared word unit: bit extract, bit toggle, row-word XOR, lowest-zero search.
// Depends on gbre_pkg.
`default_nettype none

module gbre_word_alu (
    input  wire gbre_pkg::mode_t  op,
    input  wire logic [31:0]      word_a,
    input  wire logic [31:0]      word_b,
    input  wire logic [4:0]       bit_sel,
    input  wire logic             gap_full,
    input  wire logic [4:0]       gap_bits,
    output gbre_pkg::alu_out_t    res
);
    import gbre_pkg::*;

    logic [WORD_W-1:0] bit_mask;
    logic [WORD_W-1:0] lim_mask;
    logic [WORD_W-1:0] free_bits;

    always_comb begin
        bit_mask  = WORD_W'(1) << bit_sel;
        // columns of this word that lie below the scan limit
        lim_mask  = gap_full ? '1 : ((WORD_W'(1) << gap_bits) - WORD_W'(1));
        free_bits = ~word_a & lim_mask;

        res         = '0;
        res.bit_val = word_a[bit_sel];
        case (op)
            MODE_TOGGLE: res.wr_data = word_a ^ bit_mask;
            MODE_ADD:    res.wr_data = word_a ^ word_b;
            default:     res.wr_data = word_a;
        endcase

        res.zero_found = |free_bits;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                res.zero_pos = BIT_SEL_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/gf2_bit_matrix_row_engine.sv
// GF(2) bit-matrix row engine: sequencer around one word store and one word ALU.
// Depends on gbre_pkg, gbre_word_ram, gbre_word_alu.
// Work per request: read/toggle touch one row word; add touches stride words (stride is
//   row_words clamped to 1..MAX_ROW_WORDS); find gap scans up to ceil(limit/32) words,
//   none for a zero limit, and stops when a zero turns up; errors touch no word.
// Throughput: one request at a time; the store port serves one row word per cycle.
// Reset: synchronous; a clearing pass then zeroes the store one word per cycle,
//   all ROW_COUNT * MAX_ROW_WORDS words (256 by default), with s_ready low throughout.
`default_nettype none

module gf2_bit_matrix_row_engine #(
    parameter int ROW_COUNT     = 64,
    parameter int MAX_ROW_WORDS = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_row_words,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [5:0] s_target_row,
    input  wire logic [6:0] s_second_index,
    input  wire logic [7:0] s_gap_limit,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_bit_value,
    output logic [6:0]      m_gap_position,
    output logic            m_gap_found,
    output logic            m_index_error
);
    import gbre_pkg::*;

    localparam int DEPTH = ROW_COUNT * MAX_ROW_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_ROW_WORDS + 1);
    localparam int PW    = 7 + WW;
    localparam int RW    = WW + 6;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t           state_reg,     state_next;
    logic [CFG_W-1:0] rw_reg,        rw_next;
    mode_t            mode_reg,      mode_next;
    logic [4:0]       bit_sel_reg,   bit_sel_next;
    logic [7:0]       limit_reg,     limit_next;
    logic [AW-1:0]    base_reg,      base_next;
    logic [AW-1:0]    src_base_reg,  src_base_next;
    logic [WW-1:0]    word_off_reg,  word_off_next;
    logic [WW-1:0]    total_reg,     total_next;
    logic [WW-1:0]    cnt_reg,       cnt_next;
    logic             pend_reg,      pend_next;
    logic [WW-1:0]    pend_word_reg, pend_word_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic             bit_reg,       bit_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic             found_reg,     found_next;
    logic             err_reg,       err_next;
    logic [AW-1:0]    clr_addr_reg,  clr_addr_next;
    logic             m_valid_reg,   m_valid_next;
    logic             m_bit_reg,     m_bit_next;
    logic [POS_W-1:0] m_pos_reg,     m_pos_next;
    logic             m_found_reg,   m_found_next;
    logic             m_err_reg,     m_err_next;

    logic [WW-1:0]    stride;
    mode_t            in_mode;
    logic             row_bad;
    logic             in_err;
    logic [3:0]       gap_words;
    logic [PW-1:0]    prod_dst;
    logic [PW-1:0]    prod_src;
    logic [WW-1:0]    issue_word;
    logic             issue;
    logic             gap_hit;
    logic [RW-1:0]    rem;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [31:0]      rdata_a;
    logic [31:0]      rdata_b;
    alu_out_t         alu_res;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_bit_value    = m_bit_reg;
    assign m_gap_position = m_pos_reg;
    assign m_gap_found    = m_found_reg;
    assign m_index_error  = m_err_reg;

    // ---------------- request decode ----------------
    always_comb begin
        if (rw_reg == '0) begin
            stride = WW'(1);
        end else if (32'(rw_reg) > 32'(MAX_ROW_WORDS)) begin
            stride = WW'(MAX_ROW_WORDS);
        end else begin
            stride = WW'(rw_reg);
        end

        in_mode   = mode_t'(s_mode);
        row_bad   = 32'(s_target_row) >= 32'(ROW_COUNT);
        gap_words = 4'((9'(s_gap_limit) + 9'd31) >> 5);
        prod_dst  = PW'(s_target_row) * PW'(stride);
        prod_src  = PW'(s_second_index) * PW'(stride);

        unique case (in_mode) inside
            MODE_READ, MODE_TOGGLE:
                in_err = row_bad || (32'(s_second_index[6:5]) >= 32'(stride));
            MODE_ADD:
                in_err = row_bad || (32'(s_second_index) >= 32'(ROW_COUNT));
            default:
                in_err = row_bad || (32'(s_gap_limit) > (32'(stride) << 5));
        endcase
    end

    // ---------------- word pipeline ----------------
    assign issue_word = word_off_reg + cnt_reg;
    assign raddr_a    = base_reg + AW'(issue_word);
    assign raddr_b    = src_base_reg + AW'(issue_word);
    assign rem        = RW'(limit_reg) - (RW'(pend_word_reg) << 5);
    assign gap_hit    = (state_reg == ST_RUN) && pend_reg && (mode_reg == MODE_GAP)
                        && alu_res.zero_found;
    assign issue      = (state_reg == ST_RUN) && (cnt_reg != total_reg) && !gap_hit;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = alu_res.wr_data;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_RUN && pend_reg
                     && (mode_reg == MODE_TOGGLE || mode_reg == MODE_ADD)) begin
            mem_we = 1'b1;
        end
    end

    gbre_word_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    gbre_word_alu u_alu (
        .op       (mode_reg),
        .word_a   (rdata_a),
        .word_b   (rdata_b),
        .bit_sel  (bit_sel_reg),
        .gap_full (rem >= RW'(WORD_W)),
        .gap_bits (rem[4:0]),
        .res      (alu_res)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        rw_next        = rw_reg;
        mode_next      = mode_reg;
        bit_sel_next   = bit_sel_reg;
        limit_next     = limit_reg;
        base_next      = base_reg;
        src_base_next  = src_base_reg;
        word_off_next  = word_off_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_word_next = pend_word_reg;
        pend_addr_next = pend_addr_reg;
        bit_next       = bit_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        err_next       = err_reg;
        clr_addr_next  = clr_addr_reg;
        m_valid_next   = m_valid_reg;
        m_bit_next     = m_bit_reg;
        m_pos_next     = m_pos_reg;
        m_found_next   = m_found_reg;
        m_err_next     = m_err_reg;

        if (cfg_valid && cfg_ready) begin
            rw_next = cfg_row_words;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = in_mode;
                    bit_sel_next  = s_second_index[4:0];
                    limit_next    = s_gap_limit;
                    base_next     = AW'(prod_dst);
                    src_base_next = AW'(prod_src);
                    cnt_next      = '0;
                    bit_next      = 1'b0;
                    pos_next      = '0;
                    found_next    = 1'b0;
                    err_next      = in_err;
                    if (in_mode == MODE_READ || in_mode == MODE_TOGGLE) begin
                        word_off_next = WW'(s_second_index[6:5]);
                        total_next    = WW'(1);
                    end else if (in_mode == MODE_ADD) begin
                        word_off_next = '0;
                        total_next    = stride;
                    end else begin
                        word_off_next = '0;
                        total_next    = WW'(gap_words);
                    end
                    state_next = in_err ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    pend_next      = 1'b1;
                    pend_word_next = issue_word;
                    pend_addr_next = raddr_a;
                    cnt_next       = cnt_reg + WW'(1);
                end
                if (pend_reg && mode_reg == MODE_READ) begin
                    bit_next = alu_res.bit_val;
                end
                if (gap_hit) begin
                    found_next = 1'b1;
                    pos_next   = POS_W'((RW'(pend_word_reg) << 5) + RW'(alu_res.zero_pos));
                    state_next = ST_DONE;
                end else if (!pend_reg && cnt_reg == total_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_bit_next   = bit_reg;
                    m_pos_next   = pos_reg;
                    m_found_next = found_reg;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            rw_reg       <= ROW_WORDS_RESET;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rw_reg       <= rw_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg      <= mode_next;
        bit_sel_reg   <= bit_sel_next;
        limit_reg     <= limit_next;
        base_reg      <= base_next;
        src_base_reg  <= src_base_next;
        word_off_reg  <= word_off_next;
        total_reg     <= total_next;
        cnt_reg       <= cnt_next;
        pend_word_reg <= pend_word_next;
        pend_addr_reg <= pend_addr_next;
        bit_reg       <= bit_next;
        pos_reg       <= pos_next;
        found_reg     <= found_next;
        err_reg       <= err_next;
        m_bit_reg     <= m_bit_next;
        m_pos_reg     <= m_pos_next;
        m_found_reg   <= m_found_next;
        m_err_reg     <= m_err_next;
    end

    // ---------------- assertions ----------------
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> !m_gap_found && !m_bit_value && m_gap_position == 7'd0)
        else $error("error result carries nonzero fields");

    a_no_gap_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_gap_found |-> m_gap_position == 7'd0)
        else $error("gap position set without a gap");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_CLEAR || state_reg == ST_RUN)
        else $error("store written outside clear or run");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> cnt_reg <= total_reg)
        else $error("word counter passed its total");

    a_run_leaves_on_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN && !pend_reg && cnt_reg == total_reg |=> state_reg == ST_DONE)
        else $error("run did not finish after last word");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for gf2_bit_matrix_row_engine: a predictor class mirrors the
// packed row store and checks each result; tasks drive requests and config, a process back-pressure.
// Depends on gbre_pkg and the RTL of the row engine.
`timescale 1ns / 1ps

module testbench;

    import gbre_pkg::*;

    localparam int ROWS             = 64;
    localparam int MAX_WORDS        = 4;
    localparam int STORE_WORDS      = ROWS * MAX_WORDS;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 185;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int FILL_TOGGLE_CAP  = 24;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  target_row;
        logic [6:0]  second_index;
        logic [7:0]  gap_limit;
    } request_t;

    typedef struct packed {
        logic        bit_value;
        logic [6:0]  gap_position;
        logic        gap_found;
        logic        index_error;
    } result_t;

    // Mirror of the matrix store plus the queue of results still owed by the block.
    class matrix_predictor;
        logic [WORD_W-1:0] words [STORE_WORDS];
        logic [CFG_W-1:0]  row_words;
        result_t           expected_results [$];
        int                failures;

        function new();
            foreach (words[i]) words[i] = '0;
            row_words = ROW_WORDS_RESET;
            failures  = 0;
        endfunction

        function int unsigned stride();
            if (row_words == 0) return 1;
            if (row_words > MAX_WORDS) return MAX_WORDS;
            return row_words;
        endfunction

        function logic bit_at(int unsigned row, int unsigned col);
            int unsigned w = stride();
            return words[row * w + col / WORD_W][col % WORD_W];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(request_t r);
            int unsigned w    = stride();
            int unsigned cols = w * WORD_W;
            int unsigned row  = r.target_row;
            int unsigned idx  = r.second_index;
            int unsigned lim  = r.gap_limit;
            int unsigned a;
            result_t     e    = '0;
            case (r.mode)
                MODE_READ, MODE_TOGGLE: begin
                    if (idx >= cols) begin
                        e.index_error = 1'b1;
                    end else begin
                        a = row * w + idx / WORD_W;
                        if (r.mode == MODE_READ)
                            e.bit_value = words[a][idx % WORD_W];
                        else
                            words[a][idx % WORD_W] = ~words[a][idx % WORD_W];
                    end
                end
                MODE_ADD: begin
                    // source == target clears the row, which the XOR gives for free
                    if (idx >= ROWS) begin
                        e.index_error = 1'b1;
                    end else begin
                        for (int unsigned k = 0; k < w; k++)
                            words[row * w + k] ^= words[idx * w + k];
                    end
                end
                default: begin
                    if (lim > cols) begin
                        e.index_error = 1'b1;
                    end else begin
                        for (int unsigned c = 0; c < lim; c++) begin
                            if (!words[row * w + c / WORD_W][c % WORD_W]) begin
                                e.gap_position = c[6:0];
                                e.gap_found    = 1'b1;
                                break;
                            end
                        end
                    end
                end
            endcase
            expected_results.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result bit=%0d pos=%0d found=%0d err=%0d", $time,
                         got.bit_value, got.gap_position, got.gap_found, got.index_error);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.bit_value !== want.bit_value) begin
                $display("%0t: bit_value expected %0d, actual %0d", $time,
                         want.bit_value, got.bit_value);
                failures++;
            end
            if (got.gap_position !== want.gap_position) begin
                $display("%0t: gap_position expected %0d, actual %0d", $time,
                         want.gap_position, got.gap_position);
                failures++;
            end
            if (got.gap_found !== want.gap_found) begin
                $display("%0t: gap_found expected %0d, actual %0d", $time,
                         want.gap_found, got.gap_found);
                failures++;
            end
            if (got.index_error !== want.index_error) begin
                $display("%0t: index_error expected %0d, actual %0d", $time,
                         want.index_error, got.index_error);
                failures++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_row_words;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [5:0] s_target_row;
    logic [6:0] s_second_index;
    logic [7:0] s_gap_limit;
    logic       m_valid;
    logic       m_ready;
    logic       m_bit_value;
    logic [6:0] m_gap_position;
    logic       m_gap_found;
    logic       m_index_error;

    matrix_predictor board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int items_sent     = 0;

    gf2_bit_matrix_row_engine #(
        .ROW_COUNT     (ROWS),
        .MAX_ROW_WORDS (MAX_WORDS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_row_words  (cfg_row_words),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_target_row   (s_target_row),
        .s_second_index (s_second_index),
        .s_gap_limit    (s_gap_limit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bit_value    (m_bit_value),
        .m_gap_position (m_gap_position),
        .m_gap_found    (m_gap_found),
        .m_index_error  (m_index_error)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: random stalls, or a counted hold-off when one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(result_t'{m_bit_value, m_gap_position,
                                         m_gap_found, m_index_error});
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_mode         = r.mode;
        s_target_row   = r.target_row;
        s_second_index = r.second_index;
        s_gap_limit    = r.gap_limit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(r);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_fields(mode_t m, int unsigned row, int unsigned idx,
                               int unsigned lim);
        request_t r;
        r.mode         = m;
        r.target_row   = row[5:0];
        r.second_index = idx[6:0];
        r.gap_limit    = lim[7:0];
        send_request(r);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_row_words(logic [2:0] value);
        cfg_valid     = 1'b1;
        cfg_row_words = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.row_words = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic request_t random_request();
        int unsigned cols = board.stride() * WORD_W;
        int unsigned pick = $urandom_range(99);
        request_t    r;
        r.mode         = mode_t'($urandom_range(3));
        r.target_row   = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(7));
        r.second_index = 7'($urandom_range(127));
        r.gap_limit    = 8'($urandom_range(255));
        case (r.mode)
            MODE_READ, MODE_TOGGLE: begin
                if (pick >= 10) r.second_index = 7'($urandom_range(cols - 1));
            end
            MODE_ADD: begin
                if (pick >= 50)      r.second_index = 7'($urandom_range(7));
                else if (pick >= 25) r.second_index = 7'($urandom_range(63));
                else if (pick >= 10) r.second_index = {1'b0, r.target_row};
            end
            default: begin
                if (pick >= 15)      r.gap_limit = 8'($urandom_range(cols));
                else if (pick >= 10) r.gap_limit = '0;
            end
        endcase
        return r;
    endfunction

    // Set a prefix of one row to ones, then scan the row for the first zero and read one bit.
    task automatic fill_and_scan();
        int unsigned cols    = board.stride() * WORD_W;
        int unsigned row     = $urandom_range(7);
        int unsigned span    = $urandom_range(cols);
        int unsigned reach   = 0;
        int unsigned toggles = 0;
        while (reach < span && toggles < FILL_TOGGLE_CAP) begin
            if (!board.bit_at(row, reach)) begin
                send_fields(MODE_TOGGLE, row, reach, $urandom_range(255));
                toggles++;
            end
            reach++;
        end
        send_fields(MODE_GAP, row, $urandom_range(127),
                    $urandom_range(1) ? reach : $urandom_range(cols, reach));
        send_fields(MODE_READ, row, $urandom_range(cols - 1), $urandom_range(255));
    endtask

    initial begin
        logic [2:0] cfg_plan [PHASES];
        int         target;

        cfg_plan       = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd4};
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_row_words  = '0;
        s_valid        = 1'b0;
        s_mode         = MODE_READ;
        s_target_row   = '0;
        s_second_index = '0;
        s_gap_limit    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: corners of the full-width layout
        send_fields(MODE_READ,   0,   0,   0);
        send_fields(MODE_TOGGLE, 0,   0,   0);
        send_fields(MODE_READ,   0,   0,   0);
        send_fields(MODE_TOGGLE, 63,  127, 255);
        send_fields(MODE_READ,   63,  127, 0);
        send_fields(MODE_TOGGLE, 1,   31,  0);
        send_fields(MODE_TOGGLE, 1,   32,  0);
        send_fields(MODE_GAP,    0,   0,   128);
        send_fields(MODE_GAP,    0,   0,   0);
        send_fields(MODE_GAP,    0,   0,   1);
        send_fields(MODE_GAP,    0,   0,   129);
        send_fields(MODE_GAP,    63,  127, 255);
        send_fields(MODE_GAP,    63,  0,   128);
        send_fields(MODE_ADD,    5,   0,   0);
        send_fields(MODE_READ,   5,   0,   0);
        send_fields(MODE_ADD,    5,   5,   0);
        send_fields(MODE_READ,   5,   0,   0);
        send_fields(MODE_ADD,    5,   64,  0);
        send_fields(MODE_ADD,    63,  127, 255);
        send_fields(MODE_ADD,    63,  1,   0);

        // directed: one-word rows, column and limit range errors
        settle();
        write_row_words(3'd1);
        send_fields(MODE_READ,   1,   32,  0);
        send_fields(MODE_TOGGLE, 0,   127, 0);
        send_fields(MODE_GAP,    1,   0,   33);
        send_fields(MODE_GAP,    1,   0,   32);
        send_fields(MODE_READ,   63,  31,  0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_row_words(cfg_plan[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // long result-side hold while requests keep coming
            if (p == 0) hold_left = LONG_HOLD_CYCLES;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(99) < 30)
                    fill_and_scan();
                else
                    send_request(random_request());
            end
        end

        settle();
        if (board.failures == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/core/gbre_pkg.sv
rtl/core/gbre_word_ram.sv
rtl/core/gbre_word_alu.sv
rtl/core/gf2_bit_matrix_row_engine.sv
tb/testbench.sv
